// File: rtl/swps_pkg.sv
`timescale 1ns / 1ps
package swps_pkg;
  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int CFG_BITS        = 9;
  localparam int IN_BITS         = 32;
  localparam int OUT_BITS        = 32;
endpackage

// File: rtl/swps_ram.sv
`timescale 1ns / 1ps
module swps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/sliding_window_peak_spread.sv
`timescale 1ns / 1ps
// Each accepted item goes through front retire, back pops and push on the max deque and then
// the min deque, a head read and the output state, where it waits until the output is free.
// A new item is taken only in idle, after the last result is registered at the output; the
// back pops walk each deque through the single read port of its memory, one entry at a time.
// Reset (synchronous, rst high): deques empty, counts, position and best cleared,
// window length one. No clearing pass: deque memories are only read where written.
module sliding_window_peak_spread #(
  parameter int MAX_WINDOW  = swps_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swps_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [swps_pkg::CFG_BITS-1:0] cfg_wdata,     // window_len
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [swps_pkg::IN_BITS-1:0]  s_axis_tdata,  // [31:0] sample
  input  logic                          s_axis_tlast,  // last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*swps_pkg::OUT_BITS-1:0] m_axis_tdata, // [31:0] window_spread, [63:32] best_spread
  output logic                          m_axis_tuser,  // window_full
  output logic                          m_axis_tlast   // done_res
);
  import swps_pkg::*;

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int EW = AW + SAMPLE_BITS;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FRONT = 7'b0000010,
    ST_BRD   = 7'b0000100,
    ST_BCHK  = 7'b0001000,
    ST_PUSH  = 7'b0010000,
    ST_HRD   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [CFG_BITS-1:0]    window_len;
  logic [AW-1:0]          max_head, min_head, position;
  logic [CW-1:0]          max_cnt, min_cnt, sample_count, len;
  logic [SAMPLE_BITS-1:0] best_so_far, v;
  logic                   last, sel_min;
  logic [AW-1:0]          pos;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    return (s >= (AW+1)'(MAX_WINDOW)) ? AW'(s - (AW+1)'(MAX_WINDOW)) : AW'(s);
  endfunction

  // effective window length
  logic [CW-1:0] eff_len;
  always_comb begin
    if (window_len == '0) eff_len = CW'(1);
    else if (32'(window_len) > 32'(MAX_WINDOW)) eff_len = CW'(MAX_WINDOW);
    else eff_len = CW'(window_len);
  end

  logic [SAMPLE_BITS+IN_BITS-1:0] in_ext;
  assign in_ext = {{SAMPLE_BITS{1'b0}}, s_axis_tdata};

  // memories
  logic          max_we, min_we;
  logic [AW-1:0] max_raddr, min_raddr, wslot;
  logic [EW-1:0] max_rdata, min_rdata, wentry;

  swps_ram #(.WIDTH(EW), .DEPTH(MAX_WINDOW)) u_max_ram (
    .clk(clk), .we(max_we), .waddr(wslot), .wdata(wentry),
    .raddr(max_raddr), .rdata(max_rdata)
  );
  swps_ram #(.WIDTH(EW), .DEPTH(MAX_WINDOW)) u_min_ram (
    .clk(clk), .we(min_we), .waddr(wslot), .wdata(wentry),
    .raddr(min_raddr), .rdata(min_rdata)
  );

  logic [CW-1:0] cur_cnt;
  logic [AW-1:0] cur_head, back_slot;
  assign cur_cnt   = sel_min ? min_cnt : max_cnt;
  assign cur_head  = sel_min ? min_head : max_head;
  assign back_slot = wrap({1'b0, cur_head} + (AW+1)'(cur_cnt - CW'(1)));
  assign wslot     = wrap({1'b0, cur_head} + (AW+1)'(cur_cnt));
  assign wentry    = {pos, v};

  always_comb begin
    max_raddr = max_head;
    min_raddr = min_head;
    if (state == ST_BRD) begin
      max_raddr = back_slot;
      min_raddr = back_slot;
    end
  end

  logic push_ok;
  assign push_ok = (state == ST_PUSH) && (cur_cnt < CW'(MAX_WINDOW));
  assign max_we  = push_ok && !sel_min;
  assign min_we  = push_ok && sel_min;

  logic [AW-1:0] old;
  assign old = wrap({1'b0, pos} + (AW+1)'(CW'(MAX_WINDOW) - len));

  logic [SAMPLE_BITS-1:0] back_val;
  logic                   back_pop;
  assign back_val = sel_min ? min_rdata[SAMPLE_BITS-1:0] : max_rdata[SAMPLE_BITS-1:0];
  assign back_pop = sel_min ? (back_val >= v) : (back_val <= v);

  logic [CW-1:0]          sc_next;
  logic                   full;
  logic [SAMPLE_BITS-1:0] spread, best_next;
  logic                   out_free;
  assign sc_next   = (sample_count < len) ? sample_count + CW'(1) : sample_count;
  assign full      = sc_next >= len;
  assign spread    = full ? (max_rdata[SAMPLE_BITS-1:0] - min_rdata[SAMPLE_BITS-1:0]) : '0;
  assign best_next = (full && spread > best_so_far) ? spread : best_so_far;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  logic [SAMPLE_BITS+OUT_BITS-1:0] spread_ext, best_ext;
  assign spread_ext = {{OUT_BITS{1'b0}}, spread};
  assign best_ext   = {{OUT_BITS{1'b0}}, best_next};

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_len    <= CFG_BITS'(1);
      max_head      <= '0;
      min_head      <= '0;
      max_cnt       <= '0;
      min_cnt       <= '0;
      sample_count  <= '0;
      position      <= '0;
      best_so_far   <= '0;
      sel_min       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !(state == ST_OUT && out_free)) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        window_len   <= cfg_wdata;
        max_head     <= '0;
        min_head     <= '0;
        max_cnt      <= '0;
        min_cnt      <= '0;
        sample_count <= '0;
        position     <= '0;
        best_so_far  <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            v     <= in_ext[SAMPLE_BITS-1:0];
            last  <= s_axis_tlast;
            pos   <= position;
            len   <= eff_len;
            state <= ST_FRONT;
          end
        end
        ST_FRONT: begin
          // retire the sample leaving the window
          if (sample_count >= len) begin
            if (max_cnt != '0 && max_rdata[EW-1:SAMPLE_BITS] == old) begin
              max_head <= wrap({1'b0, max_head} + (AW+1)'(1));
              max_cnt  <= max_cnt - CW'(1);
            end
            if (min_cnt != '0 && min_rdata[EW-1:SAMPLE_BITS] == old) begin
              min_head <= wrap({1'b0, min_head} + (AW+1)'(1));
              min_cnt  <= min_cnt - CW'(1);
            end
          end
          sel_min <= 1'b0;
          state   <= ST_BRD;
        end
        ST_BRD: begin
          state <= (cur_cnt == '0) ? ST_PUSH : ST_BCHK;
        end
        ST_BCHK: begin
          if (back_pop) begin
            if (sel_min) min_cnt <= min_cnt - CW'(1);
            else         max_cnt <= max_cnt - CW'(1);
            state <= ST_BRD;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_ok) begin
            if (sel_min) min_cnt <= min_cnt + CW'(1);
            else         max_cnt <= max_cnt + CW'(1);
          end
          if (sel_min) begin
            state <= ST_HRD;
          end else begin
            sel_min <= 1'b1;
            state   <= ST_BRD;
          end
        end
        ST_HRD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= full;
            m_axis_tlast  <= last;
            m_axis_tdata  <= {best_ext[OUT_BITS-1:0], spread_ext[OUT_BITS-1:0]};
            if (last) begin
              max_head     <= '0;
              min_head     <= '0;
              max_cnt      <= '0;
              min_cnt      <= '0;
              sample_count <= '0;
              position     <= '0;
              best_so_far  <= '0;
            end else begin
              sample_count <= sc_next;
              position     <= wrap({1'b0, pos} + (AW+1)'(1));
              best_so_far  <= best_next;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (max_cnt <= CW'(MAX_WINDOW)) && (min_cnt <= CW'(MAX_WINDOW)))
    else $error("deque count above depth");
  a_sc_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (sample_count <= len))
    else $error("sample count beyond window");
  a_spread_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[OUT_BITS-1:0] == '0))
    else $error("spread set without full window");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_FRONT))
    else $error("accepted item not processed");
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import swps_pkg::*;

  localparam int MAXW = MAX_WINDOW_DEF;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } sample_item_t;

  typedef struct packed {
    logic        full;
    logic [31:0] spread;
    logic [31:0] best;
    logic        done;
  } spread_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_BITS-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [2*OUT_BITS-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  sliding_window_peak_spread u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #2 clk = ~clk;

  sample_item_t pending_items[$];
  spread_res_t  expected_spreads[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  // handshake captured at the rising edge for the driver
  logic s_axis_tready_q = 1'b0;
  logic s_axis_tvalid_keep = 1'b0;

  // predictor state
  logic [31:0] mx_val[MAXW], mn_val[MAXW];
  int mx_pos[MAXW], mn_pos[MAXW];
  int mx_head, mx_cnt, mn_head, mn_cnt, seen, wpos;
  logic [31:0] best_seen;
  logic [8:0] win_reg;

  function automatic void clear_window();
    mx_head = 0; mx_cnt = 0; mn_head = 0; mn_cnt = 0;
    seen = 0; wpos = 0; best_seen = '0;
  endfunction

  function automatic spread_res_t predict_spread(sample_item_t it);
    spread_res_t r;
    int len;
    int old;
    len = (win_reg == 0) ? 1 : (win_reg > MAXW ? MAXW : int'(win_reg));
    r = '0;
    if (seen >= len) begin
      old = (wpos + MAXW - len) % MAXW;
      if (mx_cnt > 0 && mx_pos[mx_head] == old) begin
        mx_head = (mx_head + 1) % MAXW; mx_cnt--;
      end
      if (mn_cnt > 0 && mn_pos[mn_head] == old) begin
        mn_head = (mn_head + 1) % MAXW; mn_cnt--;
      end
    end
    while (mx_cnt > 0 && mx_val[(mx_head + mx_cnt - 1) % MAXW] <= it.sample) mx_cnt--;
    if (mx_cnt < MAXW) begin
      mx_val[(mx_head + mx_cnt) % MAXW] = it.sample;
      mx_pos[(mx_head + mx_cnt) % MAXW] = wpos;
      mx_cnt++;
    end
    while (mn_cnt > 0 && mn_val[(mn_head + mn_cnt - 1) % MAXW] >= it.sample) mn_cnt--;
    if (mn_cnt < MAXW) begin
      mn_val[(mn_head + mn_cnt) % MAXW] = it.sample;
      mn_pos[(mn_head + mn_cnt) % MAXW] = wpos;
      mn_cnt++;
    end
    if (seen < len) seen++;
    wpos = (wpos + 1) % MAXW;
    r.full = (seen >= len);
    if (r.full) begin
      r.spread = mx_val[mx_head] - mn_val[mn_head];
      if (r.spread > best_seen) best_seen = r.spread;
    end
    r.best = best_seen;
    r.done = it.last;
    if (it.last) clear_window();
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  task automatic queue_sample(logic [31:0] smp, logic lst);
    sample_item_t it;
    it.sample = smp;
    it.last = lst;
    pending_items.insert(pending_items.size(), it);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready_q) begin
        expected_spreads.insert(expected_spreads.size(),
                                predict_spread({s_axis_tdata, s_axis_tlast}));
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && (s_axis_tvalid_keep ||
          $urandom_range(99) >= send_idle_pct)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_items[0].sample;
        s_axis_tlast <= pending_items[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= (hold_off > 0) ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    s_axis_tready_q <= s_axis_tready;
    s_axis_tvalid_keep <= s_axis_tvalid && !s_axis_tready;
  end

  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // monitor
  always @(posedge clk) begin
    spread_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_spreads.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_spreads.pop_front();
        if (m_axis_tuser !== want.full) report_mismatch("window_full", m_axis_tuser, want.full);
        if (m_axis_tdata[31:0] !== want.spread)
          report_mismatch("window_spread", m_axis_tdata[31:0], want.spread);
        if (m_axis_tdata[63:32] !== want.best)
          report_mismatch("best_spread", m_axis_tdata[63:32], want.best);
        if (m_axis_tlast !== want.done) report_mismatch("done_res", m_axis_tlast, want.done);
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_spreads.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_window(logic [8:0] len);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_reg = len;
    clear_window();
  endtask

  function automatic logic [31:0] rand_sample(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(15);
      2: return 32'hFFFF_FFF0 | $urandom_range(15);
      default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  task automatic add_sequences(int n_items, int max_seq);
    int k;
    int seq_len;
    int mode;
    k = 0;
    while (k < n_items) begin
      seq_len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, max_seq);
      mode = $urandom_range(3);
      for (int j = 0; j < seq_len; j++)
        queue_sample(rand_sample(mode), j == seq_len - 1);
      k += seq_len;
    end
  endtask

  initial begin
    win_reg = 9'd1;
    clear_window();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: window of one, extremes, short sequence, register mid-sequence
    queue_sample(32'h0, 1'b0);
    queue_sample(32'hFFFF_FFFF, 1'b0);
    queue_sample(32'h1234_5678, 1'b1);
    wait_drained();
    write_window(9'd3);
    queue_sample(32'hFFFF_FFFF, 1'b0);
    queue_sample(32'h0, 1'b0);
    queue_sample(32'h5, 1'b0);
    queue_sample(32'h5, 1'b0);
    queue_sample(32'h5, 1'b1);
    queue_sample(32'h7, 1'b0);
    queue_sample(32'h9, 1'b1);
    queue_sample(32'h3, 1'b0);
    wait_drained();
    write_window(9'd0);
    queue_sample(32'hAAAA_5555, 1'b0);
    queue_sample(32'h5555_AAAA, 1'b1);
    wait_drained();
    write_window(9'd511);
    add_sequences(300, 300);
    wait_drained();

    // random phases
    write_window(9'd256);
    add_sequences(150, 400);
    wait_drained();
    write_window(9'd4);
    send_idle_pct = 81;
    add_sequences(200, 20);
    wait_drained();
    write_window(9'd1);
    send_idle_pct = 0; recv_stall_pct = 81;
    add_sequences(150, 10);
    wait_drained();
    write_window(9'($urandom_range(2, 16)));
    send_idle_pct = 32; recv_stall_pct = 32;
    add_sequences(150, 40);
    hold_off = 400;
    wait_drained();
    write_window(9'($urandom_range(17, 255)));
    send_idle_pct = 0; recv_stall_pct = 0;
    add_sequences(200, 300);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end
endmodule

// File: files.f
rtl/swps_pkg.sv
rtl/swps_ram.sv
rtl/sliding_window_peak_spread.sv
tb/tb_top.sv
